// ===== hw/rtl/cod_pkg.sv =====
// Shared types and fixed constants of the causal order delivery buffer.
// No dependencies; imported by the top level and the clock unit.
`timescale 1ns / 1ps
package cod_pkg;

	localparam int CLK_FIELD_W = 16;
	localparam int NUM_FIELDS  = 4;
	localparam int VCLK_W      = CLK_FIELD_W * NUM_FIELDS;
	localparam int PAY_W       = 32;
	localparam int PID_W       = 3;
	localparam int ENTRY_W     = VCLK_W + PAY_W;

	localparam logic CMD_REMOTE = 1'b0;
	localparam logic CMD_LOCAL  = 1'b1;

	localparam logic ST_DELIVERED = 1'b0;
	localparam logic ST_DROPPED   = 1'b1;

	localparam logic REG_LOCAL_ID   = 1'b0;
	localparam logic REG_PROC_COUNT = 1'b1;

	typedef logic [PID_W-1:0] pid_t;

endpackage

// ===== hw/rtl/cod_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cod_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/cod_clock.sv =====
// Local vector clock: saturating per-process counters and the causal
// readiness compare of one held entry. Depends on cod_pkg.
`timescale 1ns / 1ps
module cod_clock
	import cod_pkg::*;
#(
	parameter int MAX_PROCS  = 4,
	parameter int CLOCK_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         bump_en,
	input  logic [$clog2(MAX_PROCS)-1:0] bump_pos,
	input  pid_t                         pc,
	input  logic [VCLK_W-1:0]            entry_clock,
	output logic                         entry_ok
);

	localparam logic [CLOCK_BITS-1:0] CNT_MAX = '1;

	logic [CLOCK_BITS-1:0] lclk_q [MAX_PROCS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PROCS; i++) lclk_q[i] <= '0;
		end else if (bump_en && lclk_q[bump_pos] != CNT_MAX) begin
			lclk_q[bump_pos] <= lclk_q[bump_pos] + 1'b1;
		end
	end

	// positions at or above the process count are not compared
	always_comb begin
		entry_ok = 1'b1;
		for (int i = 0; i < MAX_PROCS; i++) begin
			if (PID_W'(i) < pc &&
			    CLK_FIELD_W'(lclk_q[i]) < entry_clock[CLK_FIELD_W*i +: CLK_FIELD_W]) begin
				entry_ok = 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/causal_order_delivery_buffer.sv =====
// Causal order delivery buffer: top level, control sequencer and held-message RAM.
// Depends on cod_pkg, cod_ram and cod_clock.
`timescale 1ns / 1ps
// Holds remote messages per sender in one RAM, in arrival order, and releases
// them when the local vector clock covers their clock. A local broadcast yields
// one result without the RAM. A remote message is checked and appended to its
// sender's list, then each scan pass reads that list entry by entry through the
// single RAM read port, and a closing step follows the last pass. A full list
// yields one dropped result. Results wait in an output register; the next message
// is taken while one waits. The RAM needs no clearing after reset.
module causal_order_delivery_buffer
	import cod_pkg::*;
#(
	parameter int MAX_PROCS     = 4,
	parameter int PENDING_DEPTH = 8,
	parameter int CLOCK_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [PID_W-1:0]  cfg_data,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  logic              command,
	input  logic [PID_W-1:0]  sender,
	input  logic [PAY_W-1:0]  payload,
	input  logic [VCLK_W-1:0] vector_clock,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [PID_W-1:0]  out_sender,
	output logic [PAY_W-1:0]  out_payload,
	output logic              status,
	output logic              last
);

	localparam int PIW  = $clog2(MAX_PROCS);
	localparam int CW   = $clog2(PENDING_DEPTH + 1);
	localparam int NENT = MAX_PROCS * PENDING_DEPTH;
	localparam int AW   = $clog2(NENT);
	localparam logic [AW-1:0] DEPTH_A = AW'(PENDING_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_EVAL   = 3'd3;
	localparam logic [2:0] S_PASS   = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0] state_q;
	pid_t       local_id_q, proc_count_q;

	logic              item_cmd_q;
	pid_t              item_snd_q;
	logic [PAY_W-1:0]  item_pay_q;
	logic [VCLK_W-1:0] item_clk_q;
	logic [PIW-1:0]    sid_q;

	logic [CW-1:0] cnt_q [MAX_PROCS];
	logic [CW-1:0] rd_q, wr_q, len_q;
	logic          hit_q;
	logic          pend_v_q;
	logic [PAY_W-1:0] pend_pay_q;

	logic             res_valid_q, status_q, last_q;
	pid_t             out_sender_q;
	logic [PAY_W-1:0] out_payload_q;

	pid_t pc_eff;
	logic out_free, snd_ok, local_ok, list_full, ev_ok, commit;
	logic [CW-1:0] cnt_cur;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic           bump_en;
	logic [PIW-1:0] bump_pos;

	logic             out_load, out_st_d, out_last_d;
	pid_t             out_snd_d;
	logic [PAY_W-1:0] out_pay_d;

	always_comb begin
		if (proc_count_q < 3'd2) pc_eff = 3'd2;
		else if (proc_count_q > PID_W'(MAX_PROCS)) pc_eff = PID_W'(MAX_PROCS);
		else pc_eff = proc_count_q;
	end

	assign out_free  = !res_valid_q || !res_stall;
	assign cnt_cur   = cnt_q[sid_q];
	assign snd_ok    = item_snd_q != '0 && item_snd_q <= pc_eff && item_snd_q != local_id_q;
	assign local_ok  = local_id_q != '0 && local_id_q <= pc_eff;
	assign list_full = cnt_cur == DEPTH_C;
	assign commit    = state_q == S_EVAL && ev_ok && (!pend_v_q || out_free);

	cod_ram #(.WIDTH(ENTRY_W), .DEPTH(NENT)) u_held (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cod_clock #(.MAX_PROCS(MAX_PROCS), .CLOCK_BITS(CLOCK_BITS)) u_clock (
		.clk         (clk),
		.arst_n      (arst_n),
		.bump_en     (bump_en),
		.bump_pos    (bump_pos),
		.pc          (pc_eff),
		.entry_clock (ram_rdata[ENTRY_W-1 -: VCLK_W]),
		.entry_ok    (ev_ok)
	);

	always_comb begin
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = AW'(sid_q) * DEPTH_A + AW'(wr_q);
		ram_raddr  = AW'(sid_q) * DEPTH_A + AW'(rd_q);
		ram_wdata  = ram_rdata;
		bump_en    = 1'b0;
		bump_pos   = sid_q;
		out_load   = 1'b0;
		out_snd_d  = item_snd_q;
		out_pay_d  = item_pay_q;
		out_st_d   = ST_DELIVERED;
		out_last_d = 1'b1;
		unique case (state_q)
			S_DECODE: begin
				if (item_cmd_q == CMD_LOCAL) begin
					out_load  = out_free;
					out_snd_d = local_id_q;
					bump_en   = out_free && local_ok;
					bump_pos  = PIW'(local_id_q - 3'd1);
				end else if (snd_ok && list_full) begin
					out_load = out_free;
					out_st_d = ST_DROPPED;
				end else if (snd_ok) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(sid_q) * DEPTH_A + AW'(cnt_cur);
					ram_wdata = {item_clk_q, item_pay_q};
				end
			end
			S_READ: ram_re = 1'b1;
			S_EVAL: begin
				if (ev_ok) begin
					// previous delivery goes out now that another one follows
					bump_en    = commit;
					out_load   = commit && pend_v_q;
					out_pay_d  = pend_pay_q;
					out_last_d = 1'b0;
				end else begin
					ram_we = 1'b1;
				end
			end
			S_FIN: begin
				out_load  = pend_v_q && out_free;
				out_pay_d = pend_pay_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_id_q   <= 3'd1;
			proc_count_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_ID:   local_id_q   <= cfg_data;
				REG_PROC_COUNT: proc_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && msg_valid) begin
			item_cmd_q <= command;
			item_snd_q <= sender;
			item_pay_q <= payload;
			item_clk_q <= vector_clock;
			sid_q      <= PIW'(sender - 3'd1);
		end
		if (commit) pend_pay_q <= ram_rdata[PAY_W-1:0];
		if (out_load) begin
			out_sender_q  <= out_snd_d;
			out_payload_q <= out_pay_d;
			status_q      <= out_st_d;
			last_q        <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
			hit_q       <= 1'b0;
			rd_q        <= '0;
			wr_q        <= '0;
			len_q       <= '0;
			for (int i = 0; i < MAX_PROCS; i++) cnt_q[i] <= '0;
		end else begin
			if (out_load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (msg_valid) state_q <= S_DECODE;
				S_DECODE: begin
					if (item_cmd_q == CMD_LOCAL || (snd_ok && list_full)) begin
						if (out_free) state_q <= S_IDLE;
					end else if (!snd_ok) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q[sid_q] <= cnt_cur + 1'b1;
						len_q        <= cnt_cur + 1'b1;
						rd_q         <= '0;
						wr_q         <= '0;
						hit_q        <= 1'b0;
						pend_v_q     <= 1'b0;
						state_q      <= S_READ;
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					if (!ev_ok || commit) begin
						if (commit) begin
							pend_v_q <= 1'b1;
							hit_q    <= 1'b1;
						end else begin
							wr_q <= wr_q + 1'b1;
						end
						rd_q    <= rd_q + 1'b1;
						state_q <= (rd_q + 1'b1 == len_q) ? S_PASS : S_READ;
					end
				end
				S_PASS: begin
					cnt_q[sid_q] <= wr_q;
					len_q        <= wr_q;
					rd_q         <= '0;
					wr_q         <= '0;
					hit_q        <= 1'b0;
					state_q      <= (hit_q && wr_q != '0) ? S_READ : S_FIN;
				end
				S_FIN: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign msg_stall   = state_q != S_IDLE;
	assign res_valid   = res_valid_q;
	assign out_sender  = out_sender_q;
	assign out_payload = out_payload_q;
	assign status      = status_q;
	assign last        = last_q;

`ifndef ASSERT_OFF
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("held delivery left behind at idle");
	a_scan_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> (rd_q < len_q && wr_q <= rd_q))
		else $error("scan pointers out of order");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PASS |-> wr_q <= DEPTH_C)
		else $error("pending count above depth");
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_stall) |=> msg_stall)
		else $error("second transfer taken while busy");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the causal order delivery buffer: directed table, then random traffic.
// Depends on cod_pkg and causal_order_delivery_buffer; predicts results from its own model or the table.
`timescale 1ns / 1ps
module testbench;
	import cod_pkg::*;

	localparam int N_PROC    = 4;
	localparam int DEPTH     = 8;
	localparam int STALL_LIM = 20000;
	localparam int DRAIN     = 64;

	typedef struct {
		pid_t        snd;
		logic [31:0] pay;
		logic        st;
		logic        lst;
	} dlv_t;

	typedef struct {
		logic        c;
		pid_t        s;
		logic [31:0] p;
		logic [63:0] v;
		int          rep;
		int          nexp;   // -1: predicted, 0: no result, 1: one typed result
		dlv_t        e;
	} row_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_we = 0;
	logic              cfg_index = REG_LOCAL_ID;
	logic [PID_W-1:0]  cfg_data = '0;
	logic              msg_valid = 0;
	logic              msg_stall;
	logic              command = CMD_REMOTE;
	logic [PID_W-1:0]  sender = '0;
	logic [PAY_W-1:0]  payload = '0;
	logic [VCLK_W-1:0] vector_clock = '0;
	logic              res_valid;
	logic              res_stall = 0;
	logic [PID_W-1:0]  out_sender;
	logic [PAY_W-1:0]  out_payload;
	logic              status;
	logic              last;

	causal_order_delivery_buffer DUT (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [15:0] vc_now [N_PROC];
	logic [31:0] h_pay [N_PROC][DEPTH];
	logic [63:0] h_clk [N_PROC][DEPTH];
	int          h_cnt [N_PROC];
	logic [2:0]  my_id = 3'd1;
	logic [2:0]  n_proc = 3'd4;
	dlv_t        due_q[$];

	int  errors = 0, msgs_sent = 0, results_seen = 0, drops_seen = 0, settings_used = 1;
	int  idle_cyc = 0;
	bit  calm = 0, hold_req = 0;

	function automatic int eff_count();
		return (n_proc < 2) ? 2 : ((n_proc > N_PROC) ? N_PROC : int'(n_proc));
	endfunction

	function automatic bit covered(logic [63:0] v, int pc);
		for (int i = 0; i < pc; i++)
			if (vc_now[i] < v[16*i +: 16]) return 0;
		return 1;
	endfunction

	function automatic void bump(int k);
		if (vc_now[k] != 16'hFFFF) vc_now[k] = vc_now[k] + 16'd1;
	endfunction

	// append one expected transfer at the tail
	function automatic void add_due(dlv_t d);
		due_q.insert(due_q.size(), d);
	endfunction

	task automatic predict_delivery(input logic c, input pid_t s, input logic [31:0] p,
			input logic [63:0] v);
		int pc, sq, i, n;
		bit again;
		pc = eff_count();
		if (c == CMD_LOCAL) begin
			add_due('{my_id, p, ST_DELIVERED, 1'b1});
			if (my_id >= 1 && my_id <= pc) bump(my_id - 1);
			return;
		end
		if (s == 0 || s > pc || s == my_id) return;
		sq = s - 1;
		if (h_cnt[sq] == DEPTH) begin
			add_due('{s, p, ST_DROPPED, 1'b1});
			return;
		end
		h_pay[sq][h_cnt[sq]] = p;
		h_clk[sq][h_cnt[sq]] = v;
		h_cnt[sq]++;
		n = 0;
		do begin
			again = 0;
			i = 0;
			while (i < h_cnt[sq]) begin
				if (covered(h_clk[sq][i], pc)) begin
					add_due('{s, h_pay[sq][i], ST_DELIVERED, 1'b0});
					n++;
					for (int j = i; j + 1 < h_cnt[sq]; j++) begin
						h_pay[sq][j] = h_pay[sq][j+1];
						h_clk[sq][j] = h_clk[sq][j+1];
					end
					h_cnt[sq]--;
					bump(sq);
					again = 1;
				end else begin
					i++;
				end
			end
		end while (again && h_cnt[sq] > 0);
		if (n > 0) due_q[due_q.size()-1].lst = 1'b1;
	endtask

	// one message transfer; typed rows replace the prediction with the table entry
	task automatic send_msg(input logic c, input pid_t s, input logic [31:0] p,
			input logic [63:0] v, input int nexp = -1, input dlv_t e = '{0, 0, 0, 0});
		int n0;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 18) begin
			msg_valid <= 0;
			@(negedge clk);
		end
		msg_valid    <= 1;
		command      <= c;
		sender       <= s;
		payload      <= p;
		vector_clock <= v;
		do @(posedge clk); while (msg_stall);
		n0 = due_q.size();
		predict_delivery(c, s, p, v);
		if (nexp >= 0) begin
			while (due_q.size() > n0) void'(due_q.pop_back());
			if (nexp == 1) add_due(e);
		end
		msgs_sent++;
	endtask

	task automatic quiesce();
		@(negedge clk);
		msg_valid <= 0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [2:0] val);
		@(negedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_LOCAL_ID) my_id = val;
		else n_proc = val;
	endtask

	function automatic logic [63:0] mk_clk(int a, int b, int c, int d);
		return {d[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	// clocks mostly close to the local clock so messages queue and then release
	function automatic logic [63:0] near_clk(pid_t s);
		logic [63:0] v;
		int off, val;
		if ($urandom_range(99) < 6) return {$urandom, $urandom};
		for (int i = 0; i < N_PROC; i++) begin
			if (i + 1 == s) off = ($urandom_range(9) == 0) ? 3 : $urandom_range(1, 2);
			else off = ($urandom_range(4) == 0) ? 1 : 0;
			val = vc_now[i] + off;
			if ($urandom_range(7) == 0) val = $urandom_range(int'(vc_now[i]));
			v[16*i +: 16] = (val > 16'hFFFF) ? 16'hFFFF : val[15:0];
		end
		return v;
	endfunction

	// receiver side
	always @(negedge clk) begin
		if (hold_req) begin
			res_stall <= 1;
			repeat (300) @(negedge clk);
			hold_req = 0;
		end else begin
			res_stall <= !calm && ($urandom_range(99) < 18);
		end
	end

	always @(posedge clk) begin
		if ((msg_valid && !msg_stall) || (res_valid && !res_stall)) idle_cyc <= 0;
		else idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= STALL_LIM) begin
			$display("timeout: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIM, due_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (due_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: sender %0d payload %h status %0d last %0d",
						out_sender, out_payload, status, last);
			end else begin
				dlv_t x;
				x = due_q.pop_front();
				if (x.st == ST_DROPPED) drops_seen++;
				if (out_sender !== x.snd || out_payload !== x.pay || status !== x.st ||
						last !== x.lst) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
							x.snd, x.pay, x.st, x.lst,
							out_sender, out_payload, status, last);
				end
			end
		end
	end

	initial begin
		row_t plan[12];
		logic [2:0] set_id [6];
		logic [2:0] set_pc [6];
		logic c;
		pid_t s;
		int pc;

		set_id = '{3'd2, 3'd4, 3'd3, 3'd1, 3'd0, 3'd5};
		set_pc = '{3'd4, 3'd4, 3'd3, 3'd2, 3'd0, 3'd7};
		foreach (vc_now[i]) vc_now[i] = '0;
		foreach (h_cnt[i]) h_cnt[i] = 0;

		plan[0]  = '{CMD_LOCAL,  3'd0, 32'h0, '0, 1, 1, '{3'd1, 32'h0, ST_DELIVERED, 1'b1}};
		plan[1]  = '{CMD_LOCAL,  3'd7, 32'hFFFF_FFFF, '1, 1, 1,
			'{3'd1, 32'hFFFF_FFFF, ST_DELIVERED, 1'b1}};
		plan[2]  = '{CMD_REMOTE, 3'd1, 32'h1111_0001, '0, 1, 0, '{0, 0, 0, 0}};  // from self
		plan[3]  = '{CMD_REMOTE, 3'd0, 32'h1111_0002, '0, 1, 0, '{0, 0, 0, 0}};
		plan[4]  = '{CMD_REMOTE, 3'd7, 32'h1111_0003, '0, 1, 0, '{0, 0, 0, 0}};
		plan[5]  = '{CMD_REMOTE, 3'd2, 32'hA, '0, 1, 1, '{3'd2, 32'hA, ST_DELIVERED, 1'b1}};
		plan[6]  = '{CMD_REMOTE, 3'd2, 32'hB, mk_clk(0, 3, 0, 0), 1, 0, '{0, 0, 0, 0}};
		plan[7]  = '{CMD_REMOTE, 3'd2, 32'hC, mk_clk(0, 2, 0, 0), 1, 0, '{0, 0, 0, 0}};
		// releases the whole chain held for sender two
		plan[8]  = '{CMD_REMOTE, 3'd2, 32'hFFFF_FFFF, mk_clk(2, 1, 0, 0), 1, -1, '{0, 0, 0, 0}};
		// fill sender three's list with messages waiting on process four
		plan[9]  = '{CMD_REMOTE, 3'd3, 32'h3000_0000, mk_clk(0, 0, 0, 3), 8, -1, '{0, 0, 0, 0}};
		plan[10] = '{CMD_REMOTE, 3'd3, 32'hDEAD_BEEF, '0, 1, 1,
			'{3'd3, 32'hDEAD_BEEF, ST_DROPPED, 1'b1}};
		plan[11] = '{CMD_REMOTE, 3'd4, 32'h4, mk_clk(16'hFFFF, 0, 0, 0), 1, 0, '{0, 0, 0, 0}};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		foreach (plan[r])
			for (int k = 0; k < plan[r].rep; k++)
				send_msg(plan[r].c, plan[r].s, plan[r].p + k, plan[r].v, plan[r].nexp, plan[r].e);
		quiesce();

		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(REG_LOCAL_ID, set_id[ph]);
			write_cfg(REG_PROC_COUNT, set_pc[ph]);
			settings_used++;
			calm = (ph == 3);
			if (ph == 1) hold_req = 1;   // receiver holds off while the sender keeps going
			for (int it = 0; it < 42; it++) begin
				pc = eff_count();
				c  = ($urandom_range(99) < 15) ? CMD_LOCAL : CMD_REMOTE;
				s  = ($urandom_range(9) != 0) ? pid_t'($urandom_range(1, pc))
					: pid_t'($urandom_range(7));
				if (ph == 2 && it == 20) quiesce();   // sender pause until all results are in
				send_msg(c, s, $urandom, near_clk(s));
			end
			quiesce();
		end
		calm = 0;

		errors += due_q.size();
		$display("sent %0d messages under %0d register settings; checked %0d results, %0d drops",
			msgs_sent, settings_used, results_seen, drops_seen);
		if (errors > 10) $display("%0d mismatches in total", errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== causal_order_delivery_buffer.f =====
hw/rtl/cod_pkg.sv
hw/rtl/cod_ram.sv
hw/rtl/cod_clock.sv
hw/rtl/causal_order_delivery_buffer.sv
tb/testbench.sv
